[src/dpm_pkg.sv]
package dpm_pkg;

    localparam int TEMP_W  = 11;
    localparam int RH_W    = 10;
    localparam int DEW_W   = 15;
    // divisor of the first divide: 2377 + t stays within 12 bits
    localparam int TDEN_W  = 12;
    // quotient bits of the rounding divide, enough for any reachable alpha
    localparam int QDEW_W  = 16;

    localparam logic [TDEN_W-1:0] T_BIAS  = 12'd2377;
    localparam logic [14:0]       SCALE   = 15'd23770;
    localparam logic [QDEW_W-1:0] DEW_MAX = 16'd10000;

    typedef logic signed [TEMP_W-1:0] t_temp;
    typedef logic [RH_W-1:0]          t_rh;
    typedef logic signed [DEW_W-1:0]  t_dew;

    // magnus coefficient a = 17.27 with f fraction bits, rounded
    function automatic longint unsigned a_fx(int f);
        return ((64'd1727 << f) + 64'd50) / 64'd100;
    endfunction

    // restoring long division, used while building the constant tables
    function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
        logic [64:0]     rem;
        longint unsigned quo;
        rem = '0;
        quo = 0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            quo = quo << 1;
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo = quo | 64'd1;
            end
        end
        return quo;
    endfunction

    // ln(num/den) with 30 fraction bits, 2*atanh series, num >= den > 0
    function automatic longint unsigned ln_q30(longint unsigned num, longint unsigned den);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned term;
        longint unsigned sum;
        z = udiv((num - den) << 30, num + den);
        z2 = (z * z) >> 30;
        term = z;
        sum = 0;
        for (int k = 0; k < 24; k++) begin
            sum = sum + udiv(term, 64'(2 * k + 1));
            term = (term * z2) >> 30;
        end
        return 2 * sum;
    endfunction

    // round half up from 30 fraction bits to f fraction bits
    function automatic longint unsigned to_frac(longint unsigned q30, int f);
        return (q30 + (64'd1 << (29 - f))) >> (30 - f);
    endfunction

endpackage

[src/dpm_if.sv]
interface dpm_in_if;
    logic            valid;
    logic            ready;
    dpm_pkg::t_temp  temp_tenths;
    dpm_pkg::t_rh    rh_tenths;

    modport source(output valid, temp_tenths, rh_tenths, input ready);
    modport sink(input valid, temp_tenths, rh_tenths, output ready);
endinterface

interface dpm_out_if;
    logic            valid;
    logic            ready;
    dpm_pkg::t_dew   dew_hundredths;
    logic            rh_invalid;

    modport source(output valid, dew_hundredths, rh_invalid, input ready);
    modport sink(input valid, dew_hundredths, rh_invalid, output ready);
endinterface

[src/dpm_div_cell.sv]
module dpm_div_cell #(
    parameter int W  = 32,
    parameter int DW = 12,
    parameter int Q  = 21,
    parameter int I  = 0,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_rem,
    input  logic [DW-1:0] i_div,
    input  logic [Q-1:0]  i_quo,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [W-1:0]  o_rem,
    output logic [DW-1:0] o_div,
    output logic [Q-1:0]  o_quo,
    output logic [SW-1:0] o_side
);

    logic [W-1:0] sh;
    logic         take;
    logic [W-1:0] n_rem;
    logic [Q-1:0] n_quo;

    // one restoring step: try divisor weighted by quotient bit I
    always_comb begin
        sh = {{(W-DW){1'b0}}, i_div} << I;
        take = (i_rem >= sh);
        n_rem = take ? (i_rem - sh) : i_rem;
        n_quo = i_quo;
        n_quo[I] = take;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= n_rem;
            o_div  <= i_div;
            o_quo  <= n_quo;
            o_side <= i_side;
        end
    end

endmodule

[src/dpm_divider.sv]
module dpm_divider #(
    parameter int W  = 32,
    parameter int DW = 12,
    parameter int Q  = 21,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [W-1:0]  i_num,
    input  logic [DW-1:0] i_div,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [Q-1:0]  o_quo,
    output logic [SW-1:0] o_side
);

    logic          v    [0:Q];
    logic [W-1:0]  rem  [0:Q];
    logic [DW-1:0] dv   [0:Q];
    logic [Q-1:0]  quo  [0:Q];
    logic [SW-1:0] side [0:Q];

    assign v[0]    = i_valid;
    assign rem[0]  = i_num;
    assign dv[0]   = i_div;
    assign quo[0]  = '0;
    assign side[0] = i_side;

    // msb first, one quotient bit per cell
    for (genvar k = 0; k < Q; k++) begin : g_cell
        dpm_div_cell #(.W(W), .DW(DW), .Q(Q), .I(Q-1-k), .SW(SW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (i_en),
            .i_valid (v[k]),
            .i_rem   (rem[k]),
            .i_div   (dv[k]),
            .i_quo   (quo[k]),
            .i_side  (side[k]),
            .o_valid (v[k+1]),
            .o_rem   (rem[k+1]),
            .o_div   (dv[k+1]),
            .o_quo   (quo[k+1]),
            .o_side  (side[k+1])
        );
    end

    assign o_valid = v[Q];
    assign o_quo   = quo[Q];
    assign o_side  = side[Q];

endmodule

[src/dpm_log.sv]
module dpm_log #(
    parameter int DEPTH = 256,
    parameter int F     = 16
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  dpm_pkg::t_rh        i_h,
    output logic signed [F+4:0] o_lnv
);

    localparam int IW = $clog2(DEPTH + 1);
    localparam int PW = 9 + IW;
    localparam int LW = F + 5;

    typedef logic [F-1:0] t_rom [0:DEPTH];

    function automatic t_rom build_rom();
        t_rom v;
        for (int k = 0; k <= DEPTH; k++) begin
            v[k] = F'(dpm_pkg::to_frac(dpm_pkg::ln_q30(longint'(DEPTH + k),
                                                        longint'(DEPTH)), F));
        end
        return v;
    endfunction

    localparam t_rom ROM = build_rom();
    localparam logic [F-1:0] LN2 = F'(dpm_pkg::to_frac(dpm_pkg::ln_q30(64'd2, 64'd1), F));
    localparam logic [F-1:0] LNC =
        F'(dpm_pkg::to_frac(dpm_pkg::ln_q30(64'd1024, 64'd1000), F));

    logic [3:0]    s;
    logic [9:0]    m;
    logic [PW-1:0] p;
    logic [IW-1:0] idx;

    logic [F-1:0]  r_lo;
    logic [F-1:0]  r_hi;
    logic [8:0]    r_r;
    logic [3:0]    r_s1;

    logic [F+8:0]  frac_p;
    logic [F+3:0]  sub;

    // normalize so that m sits in [512, 1023] for any nonzero humidity
    always_comb begin
        s = 4'd0;
        for (int i = 0; i < 10; i++) begin
            if (i_h[i]) begin
                s = 4'(9 - i);
            end
        end
        m = i_h << s;
        p = PW'(m[8:0]) * PW'(DEPTH);
        idx = IW'(p >> 9);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= ROM[idx];
            r_hi <= ROM[IW'(idx + 1'b1)];
            r_r  <= p[8:0];
            r_s1 <= s + 4'd1;
        end
    end

    // linear interpolation, then undo the normalizing shift and the 1024/1000 scale
    always_comb begin
        frac_p = (F+9)'(r_hi - r_lo) * (F+9)'(r_r);
        sub = (F+4)'(r_s1) * (F+4)'(LN2);
        o_lnv = LW'(r_lo) + LW'(frac_p >> 9) + LW'(LNC) - LW'(sub);
    end

endmodule

[src/dew_point_magnus_core.sv]
// Dew point by the Magnus formula. Each input item carries a temperature in
// tenths of a degree C and a relative humidity in tenths of a percent; each
// gives exactly one result item with the dew point in hundredths of a degree,
// saturated to +-100.00, and rh_invalid set (dew zero) when humidity is zero.
// Fixed point with FRAC_BITS fraction bits; ln(RH) comes from a registered
// ROM of LOG_TABLE_DEPTH+1 entries with linear interpolation. The two
// divides are chains of restoring cells, one quotient bit per cell, so one
// item is taken every cycle while the pipe advances. Its stages are the input
// register, log ROM read, FRAC_BITS+5 cells of the a*T/(b+T) divide, two
// stages forming alpha and the rounding operands, 16 cells of the final
// divide, and the output register. The whole pipe halts while a result waits
// at the output.
module dew_point_magnus_core #(
    parameter int LOG_TABLE_DEPTH = 256,
    parameter int FRAC_BITS       = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dpm_in_if.sink     i_in,
    dpm_out_if.source  o_out
);

    localparam int F   = FRAC_BITS;
    localparam int AW  = F + 5;     // coefficient a
    localparam int W1  = F + 16;    // |a*t|
    localparam int Q1  = F + 5;     // |a*t/(b+t)|
    localparam int LW  = F + 5;     // ln term
    localparam int ALW = F + 6;     // alpha, signed
    localparam int DNW = F + 7;     // a - alpha, signed
    localparam int MW  = F + 20;    // 23770*|alpha|
    localparam int W2  = F + 22;    // rounding dividend
    localparam int SW1 = LW + 2;
    localparam int SW2 = 3;

    localparam logic [AW-1:0] A_FX = AW'(dpm_pkg::a_fx(F));

    // pipeline advances whenever the output slot is free or being taken
    logic en;
    logic r_out_valid;
    assign en = !r_out_valid || o_out.ready;
    assign i_in.ready = en;

    // input register
    logic                   r0_v;
    dpm_pkg::t_temp         r0_t;
    dpm_pkg::t_rh           r0_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (en) begin
            r0_v <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_t <= i_in.temp_tenths;
            r0_h <= i_in.rh_tenths;
        end
    end

    // product a*|t| and divisor b+t, log ROM read alongside
    logic [dpm_pkg::TEMP_W-1:0] tmag;
    logic [dpm_pkg::TDEN_W:0]   tden;
    logic                       r1_v;
    logic [W1-1:0]              r1_prod;
    logic [dpm_pkg::TDEN_W-1:0] r1_den;
    logic                       r1_neg;
    logic                       r1_zero;
    logic signed [LW-1:0]       lnv;

    always_comb begin
        tmag = r0_t[dpm_pkg::TEMP_W-1] ? dpm_pkg::TEMP_W'(-r0_t) : dpm_pkg::TEMP_W'(r0_t);
        tden = (dpm_pkg::TDEN_W+1)'(dpm_pkg::T_BIAS) + (dpm_pkg::TDEN_W+1)'(r0_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_prod <= W1'(A_FX) * W1'(tmag);
            r1_den  <= tden[dpm_pkg::TDEN_W-1:0];
            r1_neg  <= r0_t[dpm_pkg::TEMP_W-1];
            r1_zero <= (r0_h == '0);
        end
    end

    dpm_log #(.DEPTH(LOG_TABLE_DEPTH), .F(F)) u_log (
        .i_clk (i_clk),
        .i_en  (en),
        .i_h   (r0_h),
        .o_lnv (lnv)
    );

    // temperature term divide, side carries ln, sign and zero flag
    logic           d1_v;
    logic [Q1-1:0]  d1_q;
    logic [SW1-1:0] d1_side;

    dpm_divider #(.W(W1), .DW(dpm_pkg::TDEN_W), .Q(Q1), .SW(SW1)) u_div_term (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r1_v),
        .i_num   (r1_prod),
        .i_div   (r1_den),
        .i_side  ({lnv, r1_neg, r1_zero}),
        .o_valid (d1_v),
        .o_quo   (d1_q),
        .o_side  (d1_side)
    );

    // alpha = term + ln and a - alpha
    logic signed [ALW-1:0] term_c;
    logic signed [ALW-1:0] alpha_c;
    logic signed [DNW-1:0] den_c;
    logic                  r3_v;
    logic                  r3_neg;
    logic                  r3_zero;
    logic [ALW-2:0]        r3_amag;
    logic signed [DNW-1:0] r3_den;

    always_comb begin
        term_c = d1_side[1] ? -$signed(ALW'(d1_q)) : $signed(ALW'(d1_q));
        alpha_c = term_c + ALW'($signed(d1_side[SW1-1:2]));
        den_c = $signed({2'b00, A_FX}) - DNW'(alpha_c);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v <= d1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_neg  <= alpha_c[ALW-1];
            r3_amag <= alpha_c[ALW-1] ? (ALW-1)'(-alpha_c) : (ALW-1)'(alpha_c);
            r3_den  <= den_c;
            r3_zero <= d1_side[0];
        end
    end

    // rounding operands: (2*|num| + den) / (2*den)
    logic [MW-1:0]  mag_c;
    logic           r4_v;
    logic [W2-1:0]  r4_num;
    logic [DNW-1:0] r4_div;
    logic [SW2-1:0] r4_side;
    logic           bad_c;

    always_comb begin
        mag_c = MW'(r3_amag) * MW'(dpm_pkg::SCALE);
        bad_c = r3_den[DNW-1] || (r3_den == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_num  <= W2'({mag_c, 1'b0}) + W2'(r3_den[DNW-2:0]);
            r4_div  <= {r3_den[DNW-2:0], 1'b0};
            r4_side <= {r3_neg, r3_zero, bad_c};
        end
    end

    logic                      d2_v;
    logic [dpm_pkg::QDEW_W-1:0] d2_q;
    logic [SW2-1:0]            d2_side;

    dpm_divider #(.W(W2), .DW(DNW), .Q(dpm_pkg::QDEW_W), .SW(SW2)) u_div_dew (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r4_v),
        .i_num   (r4_num),
        .i_div   (r4_div),
        .i_side  (r4_side),
        .o_valid (d2_v),
        .o_quo   (d2_q),
        .o_side  (d2_side)
    );

    // saturate, apply sign, zero humidity overrides everything
    logic [dpm_pkg::QDEW_W-1:0] qs;
    dpm_pkg::t_dew              n_dew;
    dpm_pkg::t_dew              r_dew;
    logic                       r_inv;

    always_comb begin
        qs = (d2_q > dpm_pkg::DEW_MAX) ? dpm_pkg::DEW_MAX : d2_q;
        if (d2_side[1]) begin
            n_dew = '0;
        end else if (d2_side[0]) begin
            n_dew = dpm_pkg::DEW_W'(dpm_pkg::DEW_MAX);
        end else if (d2_side[2]) begin
            n_dew = -$signed(dpm_pkg::DEW_W'(qs));
        end else begin
            n_dew = $signed(dpm_pkg::DEW_W'(qs));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= d2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dew <= n_dew;
            r_inv <= d2_side[1];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.dew_hundredths = r_dew;
    assign o_out.rh_invalid     = r_inv;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int TABLE_N  = 256;
    localparam int FB       = 16;
    localparam int N_RANDOM = 1000;
    localparam int LIMIT    = 400000;

    typedef struct {
        dpm_pkg::t_temp temp;
        dpm_pkg::t_rh   rh;
    } t_sample;

    typedef struct {
        dpm_pkg::t_dew dew;
        logic          invalid;
    } t_result;

    logic i_clk;
    logic i_rst_n;

    dpm_in_if  in_if();
    dpm_out_if out_if();

    dew_point_magnus_core #(
        .LOG_TABLE_DEPTH(TABLE_N),
        .FRAC_BITS(FB)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in(in_if.sink),
        .o_out(out_if.source)
    );

    t_sample pending_samples[$];
    t_result dew_expected[$];
    longint  ln_table[TABLE_N + 1];
    longint  ln_two;
    longint  ln_corr;
    longint  a_coef;
    int      n_sent;
    int      n_checked;
    int      n_errors;
    int      n_invalid;
    int      n_saturated;
    int      idle_pct;
    int      stall_pct;
    longint  cycles;

    // natural log of num/den with 30 fraction bits, atanh series
    function automatic longint unsigned series_ln(longint unsigned num, longint unsigned den);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned pw;
        longint unsigned acc;
        z = ((num - den) << 30) / (num + den);
        z2 = (z * z) >> 30;
        pw = z;
        acc = 0;
        for (int k = 0; k < 24; k++) begin
            acc += pw / longint'(2 * k + 1);
            pw = (pw * z2) >> 30;
        end
        return acc * 2;
    endfunction

    function automatic longint q30_round(longint unsigned v);
        return longint'((v + (64'd1 << (29 - FB))) >> (30 - FB));
    endfunction

    function automatic t_result magnus_dew(t_sample s);
        t_result d;
        longint t;
        longint tfrac;
        longint lg;
        longint alpha;
        longint den;
        longint num;
        longint mag;
        longint q;
        longint unsigned m;
        longint unsigned p;
        longint unsigned idx;
        longint unsigned r;
        int     sh;
        d.dew = '0;
        d.invalid = 1'b0;
        if (s.rh == 0) begin
            d.invalid = 1'b1;
            return d;
        end
        t = longint'(s.temp);
        tfrac = (a_coef * t) / (2377 + t);
        m = s.rh;
        sh = 0;
        while (m < 512) begin
            m = m << 1;
            sh++;
        end
        p = (m - 512) * TABLE_N;
        idx = p >> 9;
        r = p & 511;
        lg = ln_table[idx]
           + longint'((unsigned'(ln_table[idx + 1] - ln_table[idx]) * r) >> 9);
        lg = lg - longint'(sh + 1) * ln_two + ln_corr;
        alpha = tfrac + lg;
        den = a_coef - alpha;
        if (den <= 0) begin
            q = 10000;
        end else begin
            num = 23770 * alpha;
            mag = (num < 0) ? -num : num;
            q = (2 * mag + den) / (2 * den);
            if (q > 10000) q = 10000;
            if (num < 0) q = -q;
        end
        d.dew = dpm_pkg::t_dew'(q);
        return d;
    endfunction

    function automatic void add_sample(int t, int h);
        t_sample s;
        s.temp = dpm_pkg::t_temp'(t);
        s.rh = dpm_pkg::t_rh'(h);
        pending_samples.push_back(s);
    endfunction

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // idling pattern follows the number of items sent so far
    always_comb begin
        case ((n_sent * 4) / (N_RANDOM + 25))
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 68; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 68; end
            default: begin idle_pct = 13; stall_pct = 13; end
        endcase
    end

    // driver
    always @(posedge i_clk) begin
        t_sample s;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                s.temp = in_if.temp_tenths;
                s.rh = in_if.rh_tenths;
                dew_expected.push_back(magnus_dew(s));
                n_sent <= n_sent + 1;
            end
            if (!in_if.valid || in_if.ready) begin
                if (pending_samples.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    s = pending_samples.pop_front();
                    in_if.valid <= 1'b1;
                    in_if.temp_tenths <= s.temp;
                    in_if.rh_tenths <= s.rh;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result e;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= ($urandom_range(99) >= stall_pct);
            if (out_if.valid && out_if.ready) begin
                if (dew_expected.size() == 0) begin
                    $error("result item with nothing expected: dew_hundredths %0d",
                           out_if.dew_hundredths);
                    n_errors = n_errors + 1;
                end else begin
                    e = dew_expected.pop_front();
                    if (out_if.dew_hundredths !== e.dew) begin
                        $error("dew_hundredths expected %0d actual %0d",
                               e.dew, out_if.dew_hundredths);
                        n_errors = n_errors + 1;
                    end
                    if (out_if.rh_invalid !== e.invalid) begin
                        $error("rh_invalid expected %0b actual %0b",
                               e.invalid, out_if.rh_invalid);
                        n_errors = n_errors + 1;
                    end
                    if (e.invalid) n_invalid <= n_invalid + 1;
                    if (e.dew == 10000 || e.dew == -10000) n_saturated <= n_saturated + 1;
                    n_checked <= n_checked + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int t;
        int h;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        n_invalid = 0;
        n_saturated = 0;
        cycles = 0;
        in_if.valid = 1'b0;
        in_if.temp_tenths = '0;
        in_if.rh_tenths = '0;
        out_if.ready = 1'b0;
        i_rst_n = 1'b0;

        a_coef = longint'(((64'd1727 << FB) + 64'd50) / 64'd100);
        for (int k = 0; k <= TABLE_N; k++)
            ln_table[k] = q30_round(series_ln(TABLE_N + k, TABLE_N));
        ln_two = q30_round(series_ln(2, 1));
        ln_corr = q30_round(series_ln(1024, 1000));

        // directed: field extremes, zero humidity, over-range humidity and temperature
        add_sample(0, 500);
        add_sample(-400, 1000);
        add_sample(800, 1000);
        add_sample(-400, 1);
        add_sample(800, 1);
        add_sample(250, 0);
        add_sample(-1024, 0);
        add_sample(-1024, 1000);
        add_sample(1023, 1000);
        add_sample(1023, 1023);
        add_sample(-1024, 1);
        add_sample(200, 1023);
        add_sample(-1, 512);
        add_sample(1, 511);
        add_sample(0, 256);
        add_sample(0, 255);
        add_sample(350, 999);
        add_sample(-200, 2);
        add_sample(1023, 1);
        add_sample(-1024, 1023);

        // random: mostly in range, some full bit patterns
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(9) < 7) begin
                t = $urandom_range(1200) - 400;
                h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1000, 1);
            end else begin
                t = $urandom_range(2047) - 1024;
                h = $urandom_range(1023);
            end
            add_sample(t, h);
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_samples.size() != 0 || in_if.valid || dew_expected.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);

        $display("checked %0d dew point items, %0d with zero humidity, %0d saturated",
                 n_checked, n_invalid, n_saturated);
        $display("idling phases: none, sender gaps, receiver stalls, both");
        if (n_errors == 0 && dew_expected.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
